// ===== design/work_stealing_task_queues_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the work-stealing task queue block.
// Each macro states one clocked implication with reset masking.
// ----------------------------------------------------------------------------
`ifndef WORK_STEALING_TASK_QUEUES_MACROS_SVH
`define WORK_STEALING_TASK_QUEUES_MACROS_SVH

// Same-cycle implication.
`define WSTQ_ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("work_stealing_task_queues: same-cycle check failed");

// Next-cycle implication.
`define WSTQ_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("work_stealing_task_queues: next-cycle check failed");

`endif

// ===== design/wstq_pkg.sv =====
// ----------------------------------------------------------------------------
// wstq_pkg
// Sizes, codes and item types shared by the work-stealing task queue files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wstq_pkg;

   localparam int NUM_WORKERS = 8;
   localparam int QUEUE_DEPTH = 16;
   localparam int NUM_LANES   = 4;

   // Fixed field widths.
   localparam int REQ_W      = 2;
   localparam int WIDX_W     = 3;
   localparam int TAG_W      = 16;
   localparam int LANE_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int QUSED_W    = 3;
   localparam int COUNT_W    = 8;
   localparam int PEND_W     = 16;
   localparam int WCFG_W     = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // Derived storage widths.
   localparam int Q_W    = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
   localparam int WN_W   = $clog2(NUM_WORKERS + 1);
   localparam int POS_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W = $clog2(NUM_WORKERS * QUEUE_DEPTH);
   localparam int STORE_DEPTH = NUM_WORKERS * QUEUE_DEPTH;

   // Request codes.
   localparam logic [REQ_W-1:0] REQ_ENQUEUE  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_CLAIM    = 2'd1;
   localparam logic [REQ_W-1:0] REQ_COMPLETE = 2'd2;
   localparam logic [REQ_W-1:0] REQ_FLUSH    = 2'd3;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_LIMIT   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTHING = 2'd3;

   // Register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0] CSR_WORKERS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT   = 2'd1;
   localparam logic [WCFG_W-1:0]    WORKERS_RESET = 4'd8;
   localparam logic [COUNT_W-1:0]   LIMIT_RESET   = 8'd0;

   typedef struct packed {
      logic [REQ_W-1:0]  req_type;
      logic              from_worker;
      logic [WIDX_W-1:0] worker_index;
      logic [TAG_W-1:0]  task_tag;
      logic [LANE_W-1:0] task_lane;
      logic              high_priority;
      logic              enforce_limit;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TAG_W-1:0]    got_tag;
      logic [LANE_W-1:0]   got_lane;
      logic [QUSED_W-1:0]  queue_used;
      logic                was_stolen;
      logic [COUNT_W-1:0]  flushed_count;
      logic [COUNT_W-1:0]  queued_now;
      logic [PEND_W-1:0]   lane_pending_now;
   } rsp_item_type;

   typedef struct packed {
      logic [LANE_W-1:0] lane;
      logic [TAG_W-1:0]  tag;
   } entry_type;

endpackage

`default_nettype wire

// ===== design/wstq_req_if.sv =====
// ----------------------------------------------------------------------------
// wstq_req_if
// Request channel: valid, ready and one request item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface wstq_req_if ();
   logic                  valid;
   logic                  ready;
   wstq_pkg::req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

// ===== design/wstq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// wstq_rsp_if
// Result channel: valid, ready and one result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface wstq_rsp_if ();
   logic                  valid;
   logic                  ready;
   wstq_pkg::rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

// ===== design/wstq_csr_if.sv =====
// ----------------------------------------------------------------------------
// wstq_csr_if
// Configuration write channel: valid, ready, register index and data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface wstq_csr_if ();
   logic                                valid;
   logic                                ready;
   logic [wstq_pkg::CSR_IDX_W-1:0]  index;
   logic [wstq_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/work_stealing_task_queues.sv =====
// ----------------------------------------------------------------------------
// work_stealing_task_queues
// One double-ended task queue per worker, held in a single task memory, with
// front/back enqueue, own-queue pop, ring-order stealing and lane counters.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Carries
//   req_ch    in         enqueue / claim / complete / flush request items
//   rsp_ch    out        one result item per request item
//   csr_ch    in         register writes: workers_in_use, max_queued_total
//
// An item passes through an execute cycle that updates the queue pointers,
// counters and cursor and issues the single task-memory access, then a finish
// cycle that picks up the memory read data and loads the output register.
// With the result side taking items, the next request is accepted in the finish cycle of the current one.
// Reset is synchronous and clears all pointers and counters; the
// task memory is never cleared since an entry is only read after it is written.
// A result that is not taken holds the block in its finish cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "work_stealing_task_queues_macros.svh"

module work_stealing_task_queues (
   input  wire logic   clock,
   input  wire logic   reset,
   wstq_req_if.sink    req_ch,
   wstq_rsp_if.source  rsp_ch,
   wstq_csr_if.sink    csr_ch
);

   localparam int NW = wstq_pkg::NUM_WORKERS;
   localparam int QD = wstq_pkg::QUEUE_DEPTH;
   localparam int NL = wstq_pkg::NUM_LANES;

   // Sequencer codes.
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EXEC   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   // Sequencer and request holding.
   logic [1:0]              state_ff, state_in;
   wstq_pkg::req_item_type  req_ff;

   // Configuration registers.
   logic [wstq_pkg::WCFG_W-1:0]  workers_ff;
   logic [wstq_pkg::COUNT_W-1:0] limit_ff;

   // Queue control state, kept in flip-flops next to the task memory.
   logic [wstq_pkg::POS_W-1:0]   head_ff [NW];
   logic [wstq_pkg::POS_W-1:0]   head_in [NW];
   logic [wstq_pkg::FILL_W-1:0]  fill_ff [NW];
   logic [wstq_pkg::FILL_W-1:0]  fill_in [NW];
   logic [wstq_pkg::Q_W-1:0]     cursor_ff, cursor_in;
   logic [wstq_pkg::COUNT_W-1:0] total_ff, total_in;
   logic [wstq_pkg::PEND_W-1:0]  lane_ff [NL];
   logic [wstq_pkg::PEND_W-1:0]  lane_in [NL];

   // Partial result from the execute cycle.
   wstq_pkg::rsp_item_type  res_ff, res_in;
   logic                    claim_hit_ff, claim_hit_in;

   // Task memory port.
   wstq_pkg::entry_type          store_mem [wstq_pkg::STORE_DEPTH];
   wstq_pkg::entry_type          rdata_ff;
   wstq_pkg::entry_type          mem_wdata;
   logic [wstq_pkg::ADDR_W-1:0]  mem_addr;
   logic                         mem_we, mem_re;

   // Output register.
   logic                    rsp_valid_ff;
   wstq_pkg::rsp_item_type  rsp_item_ff, rsp_final;

   logic [wstq_pkg::WN_W-1:0] active_w;
   logic                      out_free, req_ready, req_take;
   logic [wstq_pkg::LANE_W-1:0] rep_lane;

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign req_ready = (state_ff == S_IDLE) || ((state_ff == S_FINISH) && out_free);
   assign req_take  = req_ch.valid && req_ready;

   assign req_ch.ready = req_ready;
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.item  = rsp_item_ff;

   // A worker count of zero acts as one, and one above the queue count is clamped.
   always_comb begin
      if (workers_ff == '0) begin
         active_w = wstq_pkg::WN_W'(1);
      end else if (int'(workers_ff) > NW) begin
         active_w = wstq_pkg::WN_W'(NW);
      end else begin
         active_w = wstq_pkg::WN_W'(workers_ff);
      end
   end

   // Execute cycle: every state update and the one memory access of the item.
   always_comb begin
      logic                        own;
      logic                        limit_hit;
      logic                        found;
      logic [wstq_pkg::Q_W-1:0]    q;
      logic [wstq_pkg::Q_W-1:0]    widx;
      logic [wstq_pkg::Q_W-1:0]    victim;
      logic [wstq_pkg::Q_W-1:0]    cand;
      logic [wstq_pkg::POS_W-1:0]  pos;
      int                          sum_i;
      int                          v_i;

      own       = 1'b0;
      limit_hit = 1'b0;
      found     = 1'b0;
      q         = '0;
      widx      = wstq_pkg::Q_W'(req_ff.worker_index);
      victim    = '0;
      cand      = '0;
      pos       = '0;
      sum_i     = 0;
      v_i       = 0;

      head_in      = head_ff;
      fill_in      = fill_ff;
      cursor_in    = cursor_ff;
      total_in     = total_ff;
      lane_in      = lane_ff;
      res_in       = res_ff;
      claim_hit_in = claim_hit_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = '0;
      mem_wdata    = '{lane: req_ff.task_lane, tag: req_ff.task_tag};

      if (state_ff == S_EXEC) begin
         res_in       = '0;
         claim_hit_in = 1'b0;
         case (req_ff.req_type)
            wstq_pkg::REQ_ENQUEUE: begin
               limit_hit = req_ff.enforce_limit && (limit_ff != '0) &&
                           (total_ff >= limit_ff);
               if (limit_hit) begin
                  res_in.status = wstq_pkg::ST_LIMIT;
               end else begin
                  own = req_ff.from_worker && (int'(req_ff.worker_index) < int'(active_w));
                  if (own) begin
                     q = widx;
                  end else if (int'(cursor_ff) < int'(active_w)) begin
                     q = cursor_ff;
                  end else begin
                     q = '0;
                  end
                  res_in.queue_used = wstq_pkg::QUSED_W'(q);
                  if (int'(fill_ff[q]) >= QD) begin
                     res_in.status = wstq_pkg::ST_FULL;
                  end else begin
                     if (!own) begin
                        if (int'(q) + 1 < int'(active_w)) begin
                           cursor_in = wstq_pkg::Q_W'(int'(q) + 1);
                        end else begin
                           cursor_in = '0;
                        end
                     end
                     if (req_ff.high_priority || own) begin
                        if (head_ff[q] == '0) begin
                           pos = wstq_pkg::POS_W'(QD - 1);
                        end else begin
                           pos = head_ff[q] - wstq_pkg::POS_W'(1);
                        end
                        head_in[q] = pos;
                     end else begin
                        sum_i = int'(head_ff[q]) + int'(fill_ff[q]);
                        if (sum_i >= QD) begin
                           sum_i = sum_i - QD;
                        end
                        pos = wstq_pkg::POS_W'(sum_i);
                     end
                     mem_we     = 1'b1;
                     mem_addr   = wstq_pkg::ADDR_W'(int'(q) * QD + int'(pos));
                     fill_in[q] = fill_ff[q] + wstq_pkg::FILL_W'(1);
                     total_in   = total_ff + wstq_pkg::COUNT_W'(1);
                     for (int i = 0; i < NL; i++) begin
                        if ((int'(req_ff.task_lane) == i) && (lane_ff[i] != '1)) begin
                           lane_in[i] = lane_ff[i] + wstq_pkg::PEND_W'(1);
                        end
                     end
                  end
               end
            end
            wstq_pkg::REQ_CLAIM: begin
               if (int'(req_ff.worker_index) < int'(active_w)) begin
                  if (fill_ff[widx] != '0) begin
                     // Own queue: pop the front.
                     found         = 1'b1;
                     victim        = widx;
                     pos           = head_ff[widx];
                     if (int'(head_ff[widx]) == QD - 1) begin
                        head_in[widx] = '0;
                     end else begin
                        head_in[widx] = head_ff[widx] + wstq_pkg::POS_W'(1);
                     end
                  end else begin
                     // Steal from the back of the first busy queue in ring order.
                     for (int off = 1; off < NW; off++) begin
                        v_i = int'(req_ff.worker_index) + off;
                        if (v_i >= int'(active_w)) begin
                           v_i = v_i - int'(active_w);
                        end
                        cand = wstq_pkg::Q_W'(v_i);
                        if (!found && (off < int'(active_w)) && (fill_ff[cand] != '0)) begin
                           found  = 1'b1;
                           victim = cand;
                        end
                     end
                     if (found) begin
                        sum_i = int'(head_ff[victim]) + int'(fill_ff[victim]) - 1;
                        if (sum_i >= QD) begin
                           sum_i = sum_i - QD;
                        end
                        pos = wstq_pkg::POS_W'(sum_i);
                        res_in.was_stolen = 1'b1;
                     end
                  end
               end
               if (found) begin
                  mem_re            = 1'b1;
                  mem_addr          = wstq_pkg::ADDR_W'(int'(victim) * QD + int'(pos));
                  fill_in[victim]   = fill_ff[victim] - wstq_pkg::FILL_W'(1);
                  total_in          = total_ff - wstq_pkg::COUNT_W'(1);
                  res_in.queue_used = wstq_pkg::QUSED_W'(victim);
                  claim_hit_in      = 1'b1;
               end else begin
                  res_in.status = wstq_pkg::ST_NOTHING;
               end
            end
            wstq_pkg::REQ_COMPLETE: begin
               for (int i = 0; i < NL; i++) begin
                  if ((int'(req_ff.task_lane) == i) && (lane_ff[i] != '0)) begin
                     lane_in[i] = lane_ff[i] - wstq_pkg::PEND_W'(1);
                  end
               end
            end
            default: begin
               res_in.flushed_count = total_ff;
               for (int i = 0; i < NW; i++) begin
                  head_in[i] = '0;
                  fill_in[i] = '0;
               end
               total_in = '0;
            end
         endcase
         res_in.queued_now = total_in;
      end
   end

   // Finish cycle: merge the claimed entry and read the reported lane counter.
   always_comb begin
      rsp_final = res_ff;
      rep_lane  = req_ff.task_lane;
      if (claim_hit_ff) begin
         rsp_final.got_tag  = rdata_ff.tag;
         rsp_final.got_lane = rdata_ff.lane;
         rep_lane           = rdata_ff.lane;
      end
      rsp_final.lane_pending_now = '0;
      for (int i = 0; i < NL; i++) begin
         if (int'(rep_lane) == i) begin
            rsp_final.lane_pending_now = lane_ff[i];
         end
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = req_take ? S_EXEC : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         workers_ff   <= wstq_pkg::WORKERS_RESET;
         limit_ff     <= wstq_pkg::LIMIT_RESET;
         cursor_ff    <= '0;
         total_ff     <= '0;
         claim_hit_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NW; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
         for (int i = 0; i < NL; i++) begin
            lane_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         total_ff     <= total_in;
         claim_hit_ff <= claim_hit_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         lane_ff      <= lane_in;
         if (csr_ch.valid) begin
            case (csr_ch.index)
               wstq_pkg::CSR_WORKERS: begin
                  workers_ff <= csr_ch.data[wstq_pkg::WCFG_W-1:0];
               end
               wstq_pkg::CSR_LIMIT: begin
                  limit_ff <= csr_ch.data;
               end
               default: begin
               end
            endcase
         end
         if ((state_ff == S_FINISH) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (req_take) begin
         req_ff <= req_ch.item;
      end
      if ((state_ff == S_FINISH) && out_free) begin
         rsp_item_ff <= rsp_final;
      end
   end

   // Task memory. A claim reads in a later execute cycle than any enqueue that
   // wrote the same entry, so reads never need forwarding.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= store_mem[mem_addr];
      end
   end

   `WSTQ_ASSERT_NEXT(a_exec_then_finish, clock, reset, state_ff == S_EXEC, state_ff == S_FINISH)
   `WSTQ_ASSERT_IMPLIES(a_one_mem_access, clock, reset, mem_we, !mem_re)
   `WSTQ_ASSERT_NEXT(a_finish_holds, clock, reset, (state_ff == S_FINISH) && !out_free, (state_ff == S_FINISH) && $stable(res_ff))
   `WSTQ_ASSERT_IMPLIES(a_hit_is_ok, clock, reset, (state_ff == S_FINISH) && claim_hit_ff, res_ff.status == wstq_pkg::ST_OK)

endmodule

`default_nettype wire
